FILE: src/acb_pkg.sv
// ----------------------------------------------------------------------------
// acb_pkg: shared types and constants of the audio burst counter
// Sample store geometry, register indexes, sequencer states and the
// payload structs of the input and result channels.
// ----------------------------------------------------------------------------
package acb_pkg;

	localparam int MAX_SAMPLES = 16384;
	localparam int SAMPLE_BITS = 32;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int IDX_W       = ADDR_W + 1;
	localparam int SUM_W       = SAMPLE_BITS + IDX_W - 1;
	localparam int MAG_W       = SAMPLE_BITS + 1;
	localparam int WSUM_W      = 48;
	localparam int CNT_W       = 8;
	localparam int TP_W        = MAG_W + 16;
	localparam int PROD_W      = TP_W + CNT_W;
	localparam int DIVC_W      = $clog2(SUM_W + 1);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam logic [14:0] COUNT_LIMIT = 15'h7FFF;

	// register indexes of the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_MIN_PEAK  = 3'd1,
		REG_MIN_GAP   = 3'd2,
		REG_HOLD      = 3'd3,
		REG_HALF_WIN  = 3'd4
	} reg_idx_t;

	// sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_LOAD  = 9'b000000001,
		ST_DIV   = 9'b000000010,
		ST_PEAK  = 9'b000000100,
		ST_WINIT = 9'b000001000,
		ST_TPLO  = 9'b000010000,
		ST_TPHI  = 9'b000100000,
		ST_MA    = 9'b001000000,
		ST_MB    = 9'b010000000,
		ST_MC    = 9'b100000000
	} state_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
	} in_t;

	typedef struct packed {
		logic [14:0] burst_count;
		logic [1:0]  command;
	} out_t;

endpackage

FILE: src/acb_ram.sv
// ----------------------------------------------------------------------------
// acb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module acb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/audio_burst_counter_unit.sv
// ----------------------------------------------------------------------------
// audio_burst_counter_unit: counts tone bursts in one recorded audio block
// Stores a recording, then runs mean, peak, envelope and run analysis.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a sample transaction is taken at a rising edge with start
//   high and busy low; one sample per cycle while loading. A sample with
//   last set closes the recording and starts the analysis (busy high).
//   Samples beyond 16384 are dropped; a dropped last still starts analysis.
//   Result: done pulses for one cycle with result valid; the receiver
//   cannot stall, the result is simply taken that cycle.
//   Config channel: cfg_ready is always high; write only while idle.
// Analysis after last, for n stored samples and half window h, in order:
//   the bit-serial mean divider, the peak pass over the n samples, the
//   window preload of w = min(h+1,n) samples, threshold*peak in a low and a
//   high half, and the envelope pass (one store read port, two reads per sample).
//   A new recording may start in the done cycle; loading runs at one sample a cycle.
// Reset clears all control state; the sample store needs no clearing since
// only written entries are read. Registers keep their values across
// recordings; sample count, sum and run counters return to reset after a result.
// ----------------------------------------------------------------------------
module audio_burst_counter_unit
	import acb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  in_t                   in_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output out_t                  result
);

	// configuration registers
	logic [15:0] thr_q;
	logic [14:0] min_peak_q, min_gap_q;
	logic [7:0]  hold_q;
	logic [6:0]  half_q;

	state_t state_q;
	logic [IDX_W-1:0]  n_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0]  dvd_q;
	logic [IDX_W-1:0]  rem_q;
	logic [DIVC_W-1:0] divc_q;
	logic signed [MAG_W:0] mean_q;
	logic [MAG_W-1:0]  peak_q;
	logic [IDX_W-1:0]  a_q;
	logic              v_q;
	logic [WSUM_W-1:0] ws_q;
	logic [TP_W-1:0]   tp_q;
	logic [PROD_W-1:0] prod_q;
	logic [IDX_W-1:0]  i_q;
	logic              addv_q, subv_q;
	logic [14:0]       loud_q, quiet_q, total_q;
	logic              burst_q;
	logic              done_q;
	out_t              result_q;

	logic [SAMPLE_BITS-1:0] rdata;
	logic [ADDR_W-1:0]      raddr;
	logic                   accept, wr_en;

	assign accept    = start && (state_q == ST_LOAD);
	assign wr_en     = accept && (n_q < IDX_W'(MAX_SAMPLES));
	assign busy      = (state_q != ST_LOAD);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	acb_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (n_q[ADDR_W-1:0]),
		.wdata (in_item.sample),
		.raddr (raddr),
		.rdata (rdata)
	);

	// magnitude of a stored sample about the mean
	logic signed [MAG_W:0] diff;
	logic [MAG_W-1:0]      mag;
	assign diff = $signed({rdata[SAMPLE_BITS-1], rdata[SAMPLE_BITS-1], rdata}) - mean_q;
	assign mag  = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];

	// divider step
	logic [IDX_W:0] div_r;
	logic           div_ge;
	assign div_r  = {rem_q, dvd_q[SUM_W-1]};
	assign div_ge = div_r >= {1'b0, n_q};

	// window bounds of the envelope pass
	logic [IDX_W:0] i_plus_h, add_idx, hi_idx;
	logic [IDX_W-1:0] lo_idx, sub_idx, win_lim;
	logic [IDX_W:0] cnt_full;
	logic           add_ok, sub_ok;
	assign i_plus_h = {1'b0, i_q} + (IDX_W+1)'(half_q);
	assign add_idx  = i_plus_h + 1'b1;
	assign add_ok   = add_idx < {1'b0, n_q};
	assign sub_ok   = i_q >= IDX_W'(half_q);
	assign sub_idx  = i_q - IDX_W'(half_q);
	assign lo_idx   = sub_ok ? sub_idx : '0;
	assign hi_idx   = (i_plus_h < {1'b0, n_q}) ? i_plus_h : {1'b0, n_q - 1'b1};
	assign cnt_full = hi_idx - {1'b0, lo_idx} + 1'b1;
	assign win_lim  = ({1'b0, IDX_W'(half_q)} + 1'b1 < {1'b0, n_q}) ?
		IDX_W'(half_q) + 1'b1 : n_q;

	// read address select
	always_comb begin
		unique case (state_q)
			ST_MA:   raddr = add_idx[ADDR_W-1:0];
			ST_MB:   raddr = sub_idx[ADDR_W-1:0];
			default: raddr = a_q[ADDR_W-1:0];
		endcase
	end

	// loud decision and run counters
	logic        loud;
	logic [14:0] loud_inc, quiet_inc;
	assign loud = (peak_q != '0) && ({ws_q, 16'b0} >= 64'(prod_q));
	assign loud_inc  = loud_q + 1'b1;
	assign quiet_inc = quiet_q + 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= 16'd3277;
			min_peak_q <= 15'd160;
			min_gap_q  <= 15'd400;
			hold_q     <= 8'd5;
			half_q     <= 7'd16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q      <= cfg_data;
				REG_MIN_PEAK:  min_peak_q <= cfg_data[14:0];
				REG_MIN_GAP:   min_gap_q  <= cfg_data[14:0];
				REG_HOLD:      hold_q     <= cfg_data[7:0];
				REG_HALF_WIN:  half_q     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q     <= '0;
			sum_q   <= '0;
			loud_q  <= '0;
			quiet_q <= '0;
			total_q <= '0;
			burst_q <= 1'b0;
			done_q  <= 1'b0;
			v_q     <= 1'b0;
			addv_q  <= 1'b0;
			subv_q  <= 1'b0;
			a_q     <= '0;
			i_q     <= '0;
			divc_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (wr_en) begin
						n_q   <= n_q + 1'b1;
						sum_q <= sum_q + SUM_W'(in_item.sample);
					end
					if (accept && in_item.last) begin
						state_q <= ST_DIV;
						rem_q   <= '0;
						divc_q  <= '0;
						if (wr_en) begin
							dvd_q <= (sum_q + SUM_W'(in_item.sample)) < 0 ?
								SUM_W'(-(sum_q + SUM_W'(in_item.sample))) :
								SUM_W'(sum_q + SUM_W'(in_item.sample));
						end else begin
							dvd_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : sum_q;
						end
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit a cycle
					rem_q  <= div_ge ? IDX_W'(div_r - {1'b0, n_q}) : div_r[IDX_W-1:0];
					dvd_q  <= {dvd_q[SUM_W-2:0], div_ge};
					divc_q <= divc_q + 1'b1;
					if (divc_q == DIVC_W'(SUM_W - 1)) begin
						state_q <= ST_PEAK;
						a_q     <= '0;
						v_q     <= 1'b0;
						peak_q  <= '0;
					end
				end
				ST_PEAK: begin
					v_q <= a_q < n_q;
					if (a_q < n_q) a_q <= a_q + 1'b1;
					if (v_q && mag > peak_q) peak_q <= mag;
					if (a_q == n_q && !v_q) begin
						state_q <= ST_WINIT;
						a_q     <= '0;
						ws_q    <= '0;
					end
				end
				ST_WINIT: begin
					v_q <= a_q < win_lim;
					if (a_q < win_lim) a_q <= a_q + 1'b1;
					if (v_q) ws_q <= ws_q + WSUM_W'(mag);
					if (a_q == win_lim && !v_q) state_q <= ST_TPLO;
				end
				ST_TPLO: begin
					tp_q    <= TP_W'(peak_q[15:0] * thr_q);
					state_q <= ST_TPHI;
				end
				ST_TPHI: begin
					tp_q    <= tp_q + {(TP_W-16)'(peak_q[MAG_W-1:16] * thr_q), 16'b0};
					i_q     <= '0;
					state_q <= ST_MA;
				end
				ST_MA: begin
					prod_q  <= PROD_W'(tp_q * cnt_full[CNT_W-1:0]);
					addv_q  <= add_ok;
					state_q <= ST_MB;
				end
				ST_MB: begin
					if (loud) begin
						loud_q  <= loud_inc;
						quiet_q <= '0;
						if (!burst_q && loud_inc >= min_peak_q) begin
							burst_q <= 1'b1;
							if (total_q < COUNT_LIMIT) total_q <= total_q + 1'b1;
						end
					end else begin
						quiet_q <= quiet_inc;
						if (quiet_inc > 15'(hold_q)) loud_q <= '0;
						if (burst_q && quiet_inc >= min_gap_q) burst_q <= 1'b0;
					end
					if (addv_q) ws_q <= ws_q + WSUM_W'(mag);
					subv_q  <= sub_ok;
					state_q <= ST_MC;
				end
				ST_MC: begin
					if (subv_q) ws_q <= ws_q - WSUM_W'(mag);
					i_q <= i_q + 1'b1;
					if (i_q + 1'b1 == n_q) begin
						// report and return to loading
						done_q               <= 1'b1;
						result_q.burst_count <= total_q;
						result_q.command     <= (total_q > 15'd3) ? 2'd3 : total_q[1:0];
						state_q <= ST_LOAD;
						n_q     <= '0;
						sum_q   <= '0;
						loud_q  <= '0;
						quiet_q <= '0;
						total_q <= '0;
						burst_q <= 1'b0;
					end else begin
						state_q <= ST_MA;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// mean, floored, latched as the divider finishes
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && divc_q == DIVC_W'(SUM_W - 1)) begin
			if (sum_q[SUM_W-1]) begin
				mean_q <= (MAG_W+1)'(-$signed({1'b0, dvd_q[SUM_W-2:0], div_ge}) -
					((div_ge ? (div_r - {1'b0, n_q}) : div_r) != '0));
			end else begin
				mean_q <= $signed({1'b0, dvd_q[MAG_W-2:0], div_ge});
			end
		end
	end

	// checks
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy)
		else $error("result while busy");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= IDX_W'(MAX_SAMPLES))
		else $error("store fill beyond depth");
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> total_q != '0)
		else $error("burst open with zero count");

endmodule
